// File: sv/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared sizes, types and decode helpers for the call/return tracer.
// ----------------------------------------------------------------------------
package crt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SYM_W = 6;
	localparam int DEPTH_W = 8;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	localparam logic [31:0] JAL_MASK  = 32'h0000_0fff;
	localparam logic [31:0] JAL_RA    = 32'h0000_00ef;
	localparam logic [31:0] JALR_MASK = 32'h0000_7fff;
	localparam logic [31:0] JALR_RA   = 32'h0000_00e7;
	localparam logic [31:0] RET_INSN  = 32'h0000_8067;

	typedef enum logic {
		ACT_ADD   = 1'b0,
		ACT_TRACE = 1'b1
	} action_t;

	typedef enum logic {
		EV_CALL   = 1'b0,
		EV_RETURN = 1'b1
	} event_kind_t;

	// lookup token walking the cell row
	typedef struct packed {
		logic               valid;
		event_kind_t        kind;
		logic [31:0]        pc;
		logic [DEPTH_W-1:0] depth;
		logic               found;
		logic [SYM_W-1:0]   index;
	} token_t;

	function automatic logic is_call(input logic [31:0] insn);
		return ((insn & JAL_MASK) == JAL_RA) || ((insn & JALR_MASK) == JALR_RA);
	endfunction

	function automatic logic is_return(input logic [31:0] insn);
		return insn == RET_INSN;
	endfunction

	// low symbol-index bits of a cell position
	function automatic logic [SYM_W-1:0] sym_of(input logic [IDX_W-1:0] idx);
		logic [IDX_W+SYM_W-1:0] w;
		w = {{SYM_W{1'b0}}, idx};
		return w[SYM_W-1:0];
	endfunction

endpackage

// File: sv/crt_cell.sv
// ----------------------------------------------------------------------------
// crt_cell
// One symbol-table entry; checks the passing token and hands it on.
// ----------------------------------------------------------------------------
module crt_cell
	import crt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [31:0]      wr_start,
	input  logic [31:0]      wr_length,
	input  logic             enabled,
	input  logic [IDX_W-1:0] cell_idx,
	input  token_t           tok_in,
	output token_t           tok_out
);

	logic [31:0] start_q;
	logic [31:0] length_q;
	logic [32:0] range_end;
	logic        hit;
	token_t      tok_next;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_q  <= wr_start;
			length_q <= wr_length;
		end
	end

	// end taken at 33 bits so a range past the top of memory does not wrap
	assign range_end = {1'b0, start_q} + {1'b0, length_q};
	assign hit = enabled && (start_q <= tok_in.pc) && (range_end > {1'b0, tok_in.pc});

	always_comb begin
		tok_next = tok_in;
		if (!tok_in.found && hit) begin
			tok_next.found = 1'b1;
			tok_next.index = sym_of(cell_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
		end else begin
			tok_out <= tok_next;
		end
	end

endmodule

// File: sv/call_return_tracer_unit.sv
// ----------------------------------------------------------------------------
// call_return_tracer_unit
// Call/return tracer for a RISC-V retire stream with a symbol range table.
// ----------------------------------------------------------------------------
// Add and trace beats that raise no event are taken one per cycle while no
// lookup is in flight. A trace beat that emits a call or return event sends a
// lookup token down a row of TABLE_ENTRIES cells, one cell per cycle, and no
// further input beat is taken until the token leaves the last cell and its
// result is loaded into the output register. The result sits in an output
// register, so a stalled result only holds back an input beat that would emit
// another event. The table needs no clearing pass after reset; entries at or
// above the fill count are never matched.
module call_return_tracer_unit
	import crt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [31:0]        range_start,
	input  logic [31:0]        range_length,
	input  logic [31:0]        pc,
	input  logic [31:0]        instruction,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               event_kind,
	output logic [31:0]        event_pc,
	output logic [DEPTH_W-1:0] nesting,
	output logic               symbol_found,
	output logic [SYM_W-1:0]   symbol_index
);

	logic [CNT_W-1:0]   entry_count_q;
	logic               call_pending_q;
	logic               return_pending_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               busy_q;
	logic               out_valid_q;
	token_t             out_q;

	logic               accept;
	logic               is_add;
	logic               will_emit;
	logic               out_free;
	logic               add_ok;
	logic               inject;
	logic [DEPTH_W-1:0] depth_dec;
	token_t             tok_head;
	token_t             chain [TABLE_ENTRIES+1];

	assign is_add    = (action_t'(action) == ACT_ADD);
	assign will_emit = !is_add && (call_pending_q || return_pending_q);
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !busy_q && (out_free || !will_emit);
	assign accept    = in_valid && in_ready;
	assign inject    = accept && will_emit;
	assign add_ok    = accept && is_add && (entry_count_q < CNT_W'(TABLE_ENTRIES));
	assign depth_dec = (depth_q == '0) ? '0 : depth_q - 1'b1;

	always_comb begin
		tok_head.valid = inject;
		tok_head.kind  = call_pending_q ? EV_CALL : EV_RETURN;
		tok_head.pc    = pc;
		tok_head.depth = call_pending_q ? depth_q : depth_dec;
		tok_head.found = 1'b0;
		tok_head.index = '0;
	end

	assign chain[0] = tok_head;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
		crt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (add_ok && (entry_count_q[IDX_W-1:0] == IDX_W'(k))),
			.wr_start (range_start),
			.wr_length(range_length),
			.enabled  (CNT_W'(k) < entry_count_q),
			.cell_idx (IDX_W'(k)),
			.tok_in   (chain[k]),
			.tok_out  (chain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q    <= '0;
			call_pending_q   <= 1'b0;
			return_pending_q <= 1'b0;
			depth_q          <= '0;
			busy_q           <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (add_ok) begin
				entry_count_q <= entry_count_q + 1'b1;
			end
			if (accept && !is_add) begin
				call_pending_q   <= is_call(instruction);
				return_pending_q <= is_return(instruction);
				if (call_pending_q) begin
					if (depth_q != DEPTH_MAX) begin
						depth_q <= depth_q + 1'b1;
					end
				end else if (return_pending_q) begin
					depth_q <= depth_dec;
				end
			end
			// hold off new beats while the token walks the row
			if (inject) begin
				busy_q <= 1'b1;
			end else if (chain[TABLE_ENTRIES].valid) begin
				busy_q <= 1'b0;
			end
			if (chain[TABLE_ENTRIES].valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain[TABLE_ENTRIES].valid) begin
			out_q <= chain[TABLE_ENTRIES];
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_q.kind;
	assign event_pc     = out_q.pc;
	assign nesting      = out_q.depth;
	assign symbol_found = out_q.found;
	assign symbol_index = out_q.index;

endmodule

// File: sv/crt_checker.sv
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks for the call/return tracer, bound to the top level.
// ----------------------------------------------------------------------------
module crt_checker
	import crt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               event_kind,
	input logic [31:0]        event_pc,
	input logic [DEPTH_W-1:0] nesting,
	input logic               symbol_found,
	input logic [SYM_W-1:0]   symbol_index
);

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a missed lookup reports index zero
	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !symbol_found |-> symbol_index == '0)
		else $error("symbol index set without a match");

	// a fresh result beat only ends a lookup, during which input is held off
	a_rise_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result beat raised while input was open");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(event_kind) && $stable(event_pc)
		&& $stable(nesting) && $stable(symbol_found) && $stable(symbol_index))
		else $error("result payload changed while stalled");

endmodule

bind call_return_tracer_unit crt_checker u_crt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.event_kind  (event_kind),
	.event_pc    (event_pc),
	.nesting     (nesting),
	.symbol_found(symbol_found),
	.symbol_index(symbol_index)
);

// File: tb/tb_call_return_tracer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_call_return_tracer_unit
// Self-checking bench for the call/return tracer: a predictor tracks the
// symbol table, pending call/return flags and call depth per accepted beat,
// and every event beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_call_return_tracer_unit;
	import crt_pkg::*;

	localparam int          IDLE_MAX    = 8;
	localparam int          CYCLE_LIMIT = 800000;
	localparam logic [31:0] NOP_INSN    = 32'h0000_0013;

	typedef struct packed {
		event_kind_t        kind;
		logic [31:0]        pc;
		logic [DEPTH_W-1:0] depth;
		logic               found;
		logic [SYM_W-1:0]   index;
	} trace_event_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [31:0]        range_start;
	logic [31:0]        range_length;
	logic [31:0]        pc;
	logic [31:0]        instruction;
	logic               out_valid;
	logic               out_ready;
	logic               event_kind;
	logic [31:0]        event_pc;
	logic [DEPTH_W-1:0] nesting;
	logic               symbol_found;
	logic [SYM_W-1:0]   symbol_index;

	// predictor state
	logic [31:0]        sym_start [TABLE_ENTRIES];
	logic [31:0]        sym_len   [TABLE_ENTRIES];
	int                 sym_fill    = 0;
	logic               call_armed  = 1'b0;
	logic               ret_armed   = 1'b0;
	logic [DEPTH_W-1:0] depth_model = '0;
	trace_event_t       event_q[$];
	trace_event_t       want_event;

	int  mismatches    = 0;
	int  n_call_events = 0;
	int  n_ret_events  = 0;
	int  n_sym_hits    = 0;
	int  depth_peak    = 0;
	int  adds_dropped  = 0;
	int  cycle_count   = 0;
	bit  tx_idle       = 1'b1;
	bit  rx_idle       = 1'b1;
	int  hold_request  = 0;
	int  rx_hold       = 0;
	int  rx_gap        = 0;

	call_return_tracer_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void lookup_symbol(input logic [31:0] addr, output logic hit,
			output logic [SYM_W-1:0] idx);
		logic [32:0] lo;
		logic [32:0] hi;
		hit = 1'b0;
		idx = '0;
		for (int k = 0; k < sym_fill; k++) begin
			lo = {1'b0, sym_start[k]};
			hi = lo + {1'b0, sym_len[k]};
			if (!hit && lo <= {1'b0, addr} && {1'b0, addr} < hi) begin
				hit = 1'b1;
				idx = SYM_W'(k);
			end
		end
	endfunction

	function automatic void push_event(input event_kind_t kind, input logic [31:0] addr);
		trace_event_t ev;
		ev.kind  = kind;
		ev.pc    = addr;
		ev.depth = depth_model;
		lookup_symbol(addr, ev.found, ev.index);
		event_q.push_back(ev);
		if (kind == EV_CALL) n_call_events++;
		else n_ret_events++;
		if (ev.found) n_sym_hits++;
	endfunction

	function automatic void predict_beat(input action_t act, input logic [31:0] start,
			input logic [31:0] len, input logic [31:0] addr, input logic [31:0] insn);
		if (act == ACT_ADD) begin
			if (sym_fill < TABLE_ENTRIES) begin
				sym_start[sym_fill] = start;
				sym_len[sym_fill]   = len;
				sym_fill++;
			end else begin
				adds_dropped++;
			end
			return;
		end
		// the event belongs to the instruction after the call or return
		if (call_armed) begin
			push_event(EV_CALL, addr);
			if (depth_model != DEPTH_MAX) depth_model++;
			if (int'(depth_model) > depth_peak) depth_peak = depth_model;
		end else if (ret_armed) begin
			if (depth_model != '0) depth_model--;
			push_event(EV_RETURN, addr);
		end
		call_armed = ((insn & JAL_MASK) == JAL_RA) || ((insn & JALR_MASK) == JALR_RA);
		ret_armed  = (insn == RET_INSN);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_beat(action_t'(action), range_start, range_length, pc, instruction);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (event_q.size() == 0) begin
				$display("%0t: event beat with nothing expected: kind %0d pc 0x%0h",
					$time, event_kind, event_pc);
				mismatches++;
			end else begin
				want_event = event_q.pop_front();
				check_field("event_kind", want_event.kind, event_kind);
				check_field("event_pc", want_event.pc, event_pc);
				check_field("nesting", want_event.depth, nesting);
				check_field("symbol_found", want_event.found, symbol_found);
				check_field("symbol_index", want_event.index, symbol_index);
			end
		end
	end

	// result side: while rx_idle is set, stall each event beat for a random count
	// of valid cycles, or hold off entirely while a long hold is running
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				rx_hold = hold_request;
				hold_request = 0;
			end
			if (out_valid && out_ready) rx_gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
			else if (out_valid && rx_gap > 0) rx_gap--;
			if (rx_hold > 0) rx_hold--;
			out_ready <= (rx_hold == 0) && (rx_gap == 0);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run timed out, %0d events still expected", $time, event_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic send_beat(input action_t act, input logic [31:0] start,
			input logic [31:0] len, input logic [31:0] addr, input logic [31:0] insn);
		int gap;
		gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		range_start  <= start;
		range_length <= len;
		pc           <= addr;
		instruction  <= insn;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic add_range(input logic [31:0] start, input logic [31:0] len);
		send_beat(ACT_ADD, start, len, $urandom, $urandom);
	endtask

	task automatic trace_insn(input logic [31:0] addr, input logic [31:0] insn);
		send_beat(ACT_TRACE, $urandom, $urandom, addr, insn);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (event_q.size() != 0);
	endtask

	function automatic logic [31:0] call_word();
		if ($urandom_range(0, 1)) return ($urandom & ~JAL_MASK) | JAL_RA;
		return ($urandom & ~JALR_MASK) | JALR_RA;
	endfunction

	// one flipped bit away from a call or return pattern
	function automatic logic [31:0] near_miss_word();
		case ($urandom_range(0, 2))
			0: return RET_INSN ^ (32'h1 << $urandom_range(0, 31));
			1: return (($urandom & ~JAL_MASK) | JAL_RA) ^ (32'h1 << $urandom_range(0, 11));
			default: return (($urandom & ~JALR_MASK) | JALR_RA) ^ (32'h1 << $urandom_range(0, 14));
		endcase
	endfunction

	// bias addresses toward stored ranges and their edges
	function automatic logic [31:0] pick_pc();
		int k;
		if (sym_fill == 0 || $urandom_range(0, 3) == 0) return $urandom;
		k = $urandom_range(0, sym_fill - 1);
		case ($urandom_range(0, 5))
			0: return sym_start[k] - 1;
			1: return sym_start[k] + sym_len[k];
			2: return sym_start[k];
			default: return (sym_len[k] == 0) ? sym_start[k] : sym_start[k] + ($urandom % sym_len[k]);
		endcase
	endfunction

	task automatic test_symbol_table();
		add_range(32'h0000_0000, 32'h0000_0010);
		add_range(32'h8000_1000, 32'h0000_0100);
		add_range(32'h8000_1080, 32'h0000_0100);   // overlaps the one before
		add_range(32'h8000_2000, 32'h0000_0000);   // empty, never matches
		add_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);   // end runs past the top of memory
		add_range(32'hFFFF_FF00, 32'h0000_0100);
		add_range(32'h0000_4000, 32'h0000_0001);
	endtask

	task automatic test_call_return_basics();
		trace_insn(32'h8000_1000, RET_INSN);
		trace_insn(32'h0000_0000, 32'h0000_0000);  // return at depth zero
		trace_insn(32'h8000_10C0, JAL_RA);
		trace_insn(32'h8000_1100, 32'h0000_80E7);
		trace_insn(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		trace_insn(32'hFFFF_FF80, RET_INSN);
		trace_insn(32'hFFFF_FFF8, RET_INSN);
		trace_insn(32'h8000_2000, 32'h0000_80EF);
		trace_insn(32'h0000_4000, RET_INSN ^ 32'h1);
		trace_insn(32'h0000_4001, 32'h0000_80E6);
		trace_insn(32'h0000_4001, JAL_RA ^ 32'h1);
		trace_insn(32'h1234_5678, JALR_RA);
		trace_insn(32'h0000_4001, 32'h0000_F0E7);
		trace_insn(32'h0000_0010, RET_INSN | 32'h0001_0000);
		trace_insn(32'h0000_0000, RET_INSN);
		// an add between trace beats keeps the pending return
		add_range(32'h9000_0000, 32'h0000_0010);
		trace_insn(32'h9000_0008, NOP_INSN);
		trace_insn(32'h8000_10FF, RET_INSN);
		trace_insn(32'h8000_117F, NOP_INSN);
	endtask

	task automatic test_depth_limits();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (270) trace_insn(pick_pc(), call_word());
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (270) trace_insn(pick_pc(), RET_INSN);
		trace_insn(pick_pc(), NOP_INSN);
	endtask

	task automatic test_backpressure();
		tx_idle = 1'b0;
		hold_request = 400;
		repeat (40) trace_insn(pick_pc(), $urandom_range(0, 1) ? call_word() : RET_INSN);
		wait_drained();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_stream();
		int          adds_left;
		int          pick;
		logic [31:0] insn;
		adds_left = TABLE_ENTRIES - sym_fill + 6;
		for (int n = 0; n < 620; n++) begin
			if (n % 100 == 0) begin
				tx_idle = ($urandom_range(0, 3) != 0);
				rx_idle = ($urandom_range(0, 3) != 0);
			end
			if (adds_left > 0 && $urandom_range(0, 5) == 0) begin
				// the last adds land on a full table and would match everything
				if (adds_left <= 2) add_range(32'h0000_0000, 32'hFFFF_FFFF);
				else if ($urandom_range(0, 3) == 0) add_range($urandom, $urandom);
				else add_range($urandom, $urandom_range(0, 1024));
				adds_left--;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 25) insn = call_word();
				else if (pick < 50) insn = RET_INSN;
				else if (pick < 62) insn = near_miss_word();
				else insn = $urandom;
				trace_insn(pick_pc(), insn);
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_ADD;
		range_start  = '0;
		range_length = '0;
		pc           = '0;
		instruction  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_symbol_table();
		test_call_return_basics();
		test_depth_limits();
		test_backpressure();
		test_random_stream();

		wait_drained();
		repeat (TABLE_ENTRIES + 16) @(posedge clk);

		$display("Checked %0d call and %0d return events, %0d inside a symbol; depth peaked at %0d.",
			n_call_events, n_ret_events, n_sym_hits, depth_peak);
		$display("Table held %0d ranges, %0d adds dropped while full, %0d mismatches.",
			sym_fill, adds_dropped, mismatches);
		if (mismatches == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: call_return_tracer_unit.f
sv/crt_pkg.sv
sv/crt_cell.sv
sv/call_return_tracer_unit.sv
sv/crt_checker.sv
tb/tb_call_return_tracer_unit.sv
